@@ design/sha_pkg.sv @@
// sha_pkg: shared types, constants and functions for the sha-256 byte hasher
// no dependencies
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_EMIT
  } sha_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_byte;    // write in byte at fill position
    logic       pad_write;    // write pad byte at pad position
    logic       comp_start;   // load working vars, clear round counter
    logic       comp_round;   // run one round
    logic       fold;         // add working vars into hash
    logic       emit_load;    // load output register
    logic       reset_msg;    // restore initial state
  } sha_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic block_full;   // fill count wrapped after a byte
    logic round_last;   // round 63 running
  } sha_stat_t;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ design/sha_datapath.sv @@
// sha_datapath: block buffer, message schedule, round logic, hash words, bit length
// depends on sha_pkg
module sha_datapath
  import sha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sha_cmd_t  cmd,
  input  logic [7:0] in_byte,
  input  logic [5:0] pad_pos,
  input  logic [7:0] pad_byte,
  input  logic [2:0] emit_idx,
  output sha_stat_t stat,
  output logic [5:0] fill,
  output logic [63:0] msg_bits,
  output logic [31:0] emit_word
);

  // block buffer as 16 words; schedule window reuses it as a shift line
  logic [31:0] w [16];
  logic [31:0] hash [8];
  logic [31:0] v [8];
  logic [5:0]  round;
  logic [6:0]  fill_sum;
  logic [31:0] s0, s1, w_new, t1, t2, ch, mj;

  assign fill_sum = {1'b0, fill} + 7'd1;
  assign stat.block_full = cmd.load_byte && fill_sum[6];
  assign stat.round_last = (round == 6'd63);

  always_comb begin
    s0 = ror(w[1], 7) ^ ror(w[1], 18) ^ (w[1] >> 3);
    s1 = ror(w[14], 17) ^ ror(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) + ch + K[round] + w[0];
    t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + mj;
  end

  // byte write into the word array
  function automatic logic [31:0] put_byte(input logic [31:0] wd, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = wd;
    r[(3 - lane) * 8 +: 8] = b;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      w[fill[5:2]] <= put_byte(w[fill[5:2]], fill[1:0], in_byte);
    end else if (cmd.pad_write) begin
      w[pad_pos[5:2]] <= put_byte(w[pad_pos[5:2]], pad_pos[1:0], pad_byte);
    end else if (cmd.comp_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= w_new;
    end
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (cmd.comp_round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (cmd.emit_load) emit_word <= hash[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) hash[i] <= H0[i];
      fill <= '0;
      msg_bits <= '0;
      round <= '0;
    end else begin
      if (cmd.load_byte) begin
        fill <= fill_sum[5:0];
        msg_bits <= msg_bits + 64'd8;
      end
      if (cmd.comp_start) round <= '0;
      else if (cmd.comp_round) round <= round + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
      end
    end
  end

endmodule

@@ design/sha_control.sv @@
// sha_control: sequencer for byte intake, padding, compression and digest output
// depends on sha_pkg
module sha_control
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sha_in_t    in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_idx,
  input  sha_stat_t  stat,
  input  logic [5:0] fill,
  input  logic [63:0] msg_bits,
  output sha_cmd_t   cmd,
  output logic [5:0] pad_pos,
  output logic [7:0] pad_byte,
  output logic [2:0] emit_idx
);

  sha_state_t state, state_next;
  logic       ending, ending_next;   // message end pending after compression
  logic       final_blk, final_blk_next;
  logic [5:0] ppos, ppos_next;
  logic       started, started_next; // 0x80 already written
  logic [2:0] idx, idx_next;
  logic       ov, ov_next;
  logic       acc;

  assign in_ready = (state == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign pad_pos = ppos;
  assign emit_idx = idx;
  assign out_valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ending <= 1'b0;
      final_blk <= 1'b0;
      ppos <= '0;
      started <= 1'b0;
      idx <= '0;
      ov <= 1'b0;
      out_idx <= '0;
    end else begin
      state <= state_next;
      ending <= ending_next;
      final_blk <= final_blk_next;
      ppos <= ppos_next;
      started <= started_next;
      idx <= idx_next;
      ov <= ov_next;
      if (cmd.emit_load) out_idx <= idx;
    end
  end

  always_comb begin
    state_next = state;
    ending_next = ending;
    final_blk_next = final_blk;
    ppos_next = ppos;
    started_next = started;
    idx_next = idx;
    ov_next = ov;
    cmd = '0;
    pad_byte = 8'h00;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd.load_byte = in_item.byte_present;
          ending_next = in_item.end_of_message;
          started_next = 1'b0;
          final_blk_next = 1'b0;
          if (in_item.byte_present && stat.block_full) begin
            state_next = ST_COMP;
            cmd.comp_start = 1'b1;
          end else if (in_item.end_of_message) begin
            state_next = ST_PAD;
            ppos_next = in_item.byte_present ? fill + 6'd1 : fill;
          end
        end
      end
      ST_PAD: begin
        // one pad byte a cycle; length bytes fill 56..63 of the final block
        cmd.pad_write = 1'b1;
        if (!started) begin
          pad_byte = PAD_BYTE;
          started_next = 1'b1;
        end else if (final_blk && ppos >= 6'd56) begin
          pad_byte = msg_bits[(7 - ppos[2:0]) * 8 +: 8];
        end
        if (!started && ppos < 6'd56) final_blk_next = 1'b1;
        if (started && ppos == 6'd55 && !final_blk) final_blk_next = 1'b0;
        ppos_next = ppos + 6'd1;
        if (ppos == 6'd63) begin
          state_next = ST_COMP;
          cmd.comp_start = 1'b1;
        end
      end
      ST_COMP: begin
        cmd.comp_round = 1'b1;
        if (stat.round_last) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (!ending) begin
          state_next = ST_IDLE;
        end else if (!started) begin
          // block filled by the closing byte: padding starts a new block
          state_next = ST_PAD;
          ppos_next = '0;
        end else if (!final_blk) begin
          state_next = ST_PAD;
          ppos_next = '0;
          final_blk_next = 1'b1;
        end else begin
          state_next = ST_EMIT;
          idx_next = '0;
        end
      end
      ST_EMIT: begin
        if (!ov || out_ready) begin
          if (ov && out_idx == 3'd7) begin
            ov_next = 1'b0;
            cmd.reset_msg = 1'b1;
            ending_next = 1'b0;
            state_next = ST_IDLE;
          end else if (!ov || idx != 3'd0) begin
            cmd.emit_load = 1'b1;
            ov_next = 1'b1;
            idx_next = idx + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/sha256_byte_stream_hasher.sv @@
// sha-256 over a byte stream, one byte per input transfer
// a full block is compressed at one round per cycle; end of message adds up to two
// pad passes and two compressions, then 8 output transfers
// input is held off (in_ready low) while padding, compressing or emitting the digest
// reset: synchronous, loads initial hash values and clears length and fill count
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  sha_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sha_out_t out_data
);

  sha_cmd_t   cmd;
  sha_stat_t  stat;
  logic [5:0] fill, pad_pos;
  logic [7:0] pad_byte;
  logic [2:0] emit_idx, out_idx;
  logic [63:0] msg_bits;
  logic [31:0] emit_word;

  sha_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_item(in_data), .out_valid, .out_ready,
    .out_idx, .stat, .fill, .msg_bits, .cmd, .pad_pos, .pad_byte, .emit_idx
  );

  sha_datapath u_dp (
    .clk, .rst, .cmd, .in_byte(in_data.msg_byte), .pad_pos, .pad_byte, .emit_idx,
    .stat, .fill, .msg_bits, .emit_word
  );

  assign out_data.digest_word = emit_word;
  assign out_data.word_index = out_idx;
  assign out_data.last_word = (out_idx == 3'd7);

endmodule

@@ tb/tb_top.sv @@
// testbench for sha256_byte_stream_hasher: byte-stream messages against a local sha-256 predictor
// depends on sha_pkg (payload types) and the hasher rtl
`timescale 1ns / 1ps

class digest_board;
  sha_pkg::sha_out_t pending[$];
  logic [31:0] hw[8];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [63:0] nbits;
  int mismatches;
  int words_seen;
  int messages;

  localparam logic [31:0] RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function new();
    mismatches = 0;
    words_seen = 0;
    messages = 0;
    restart();
  endfunction

  function void restart();
    hw = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
           32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    fill = 0;
    nbits = '0;
  endfunction

  function logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2, ch, mj;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hw;
    for (int i = 0; i < 64; i++) begin
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch + RC[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hw[i] += v[i];
  endfunction

  // note one accepted input transfer
  function void note_byte(sha_pkg::sha_in_t it);
    int unsigned pos;
    sha_pkg::sha_out_t r;
    if (it.byte_present) begin
      blk[fill] = it.msg_byte;
      fill++;
      if (fill == 64) begin
        compress();
        nbits += 64'd512;
        fill = 0;
      end
    end
    if (!it.end_of_message) return;
    pos = fill;
    nbits += 64'(pos * 8);
    blk[pos] = 8'h80;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        blk[pos] = 8'h00;
        pos++;
      end
      compress();
      pos = 0;
    end
    while (pos < 56) begin
      blk[pos] = 8'h00;
      pos++;
    end
    for (int i = 0; i < 8; i++) blk[56+i] = nbits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      r.digest_word = hw[i];
      r.word_index = 3'(i);
      r.last_word = (i == 7);
      pending.push_back(r);
    end
    messages++;
    restart();
  endfunction

  function void check_word(sha_pkg::sha_out_t got);
    sha_pkg::sha_out_t exp;
    words_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected digest word %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("digest mismatch: exp word=%h idx=%0d last=%b got word=%h idx=%0d last=%b",
                 exp.digest_word, exp.word_index, exp.last_word,
                 got.digest_word, got.word_index, got.last_word);
    end
  endfunction
endclass

module tb_top;
  import sha_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  sha_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  sha_out_t out_data;

  int send_idle = 32;
  int recv_idle = 59;
  bit hold_recv = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  int items_sent = 0;

  digest_board board;

  always #1 clk = ~clk;

  sha256_byte_stream_hasher u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // monitor both channels and run the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_byte(in_data);
      if (out_valid && out_ready) board.check_word(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall, optional long hold-off
  always @(posedge clk) begin
    if (rst || hold_recv) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // valid stays up after a transfer so the next item can follow in the cycle after it
  task automatic send_byte(logic [7:0] b, bit present, bit eom);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{msg_byte: b, byte_present: present, end_of_message: eom};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_message(int len, bit empty_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom), 0, 0);
      send_byte(8'($urandom), 1, (!empty_end && i == len - 1));
    end
    if (empty_end || len == 0) send_byte(8'($urandom), 0, 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0 && idle_cycles < WATCHDOG) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic int pick_len();
    int k;
    k = $urandom_range(9);
    if (k < 6) return $urandom_range(12);
    return $urandom_range(70, 50);
  endfunction

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty, extremes, pad boundaries, idle items
    send_byte(8'h00, 0, 0);
    send_byte(8'h00, 0, 1);
    send_byte(8'hff, 1, 1);
    send_byte(8'h00, 1, 1);
    send_byte(8'h61, 1, 0); send_byte(8'h62, 1, 0); send_byte(8'h63, 1, 1);
    send_message(56, 1);
    send_message(64, 0);
    drain();

    // sender pause until every digest word is out, done by drain between phases
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 59; recv_idle = 32; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      for (int m = 0; m < 2; m++) send_message(pick_len(), $urandom_range(1));
      if (ph == 0) begin
        fork
          begin
            hold_recv = 1;
            repeat (600) @(posedge clk);
            hold_recv = 0;
          end
          begin
            for (int m = 0; m < 3; m++) send_message($urandom_range(6), 0);
            in_valid <= 0;
          end
        join
      end
      drain();
    end

    // cover the upper rotations of the full sequence through a clean stretch
    for (int m = 0; m < 3; m++) send_message($urandom_range(20), $urandom_range(1));
    drain();

    if (idle_cycles >= WATCHDOG) timed_out = 1;
    $display("run covered %0d input transfers, %0d messages, %0d digest words",
             items_sent, board.messages, board.words_seen);
    if (!timed_out && board.mismatches == 0 && board.pending.size() == 0)
      $display("sha256_byte_stream_hasher verification clean");
    else
      $display("sha256_byte_stream_hasher verification failed");
    $finish;
  end

  // watchdog on progress
  initial begin
    wait (idle_cycles >= WATCHDOG);
    $display("watchdog expired");
    $display("sha256_byte_stream_hasher verification failed");
    $finish;
  end
endmodule
